// ===== rtl/core/rrq_pkg.sv =====
// Shared types and codes for the round-robin run queue.
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int THREAD_W = 8;
  localparam int PRIO_W   = 8;

  // Command codes carried by an input word.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_PICK   = 2'd3
  } cmd_t;

  // Error codes returned in a result word.
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

  // One slot of the thread table as held in the slot memory.
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [PRIO_W-1:0]   prio;
  } slot_entry_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LATCH,
    DP_ADD,
    DP_PICK,
    DP_PICK_RD,
    DP_REM_RD,
    DP_REM_CMP,
    DP_SH_RD,
    DP_SH_CMP,
    DP_SORT_INIT,
    DP_SX_RD,
    DP_SX_LD,
    DP_SM_RD,
    DP_SM_CMP,
    DP_SX_WB,
    DP_LOAD_OUT
  } dp_op_t;

  // Status flags returned by the datapath to the controller.
  typedef struct packed {
    logic free_any;
    logic used_any;
    logic run_short;
    logic hit;
    logic hit_shared;
    logic scan_last;
    logic m_last;
    logic x_last;
  } dp_status_t;

endpackage

// ===== rtl/core/rrq_dp.sv =====
// Datapath of the run queue: slot memory, occupancy and shared bits, scan counters.
`timescale 1ns / 1ps

module rrq_dp #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrq_pkg::dp_op_t                 op,
  input  logic [rrq_pkg::THREAD_W-1:0]    in_thread_id,
  input  logic [rrq_pkg::PRIO_W-1:0]      in_priority_value,
  output rrq_pkg::dp_status_t             status,
  output logic [rrq_pkg::THREAD_W-1:0]    out_picked_thread,
  output logic                            out_picked_valid,
  output logic [1:0]                      out_error_code
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CUR_W = $clog2(SLOT_COUNT + 1);

  // Slot memory and its registered read port.
  rrq_pkg::slot_entry_t slot_mem_r [SLOT_COUNT];
  rrq_pkg::slot_entry_t rd_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  rrq_pkg::slot_entry_t mem_wdata;

  // Per-slot flags and the current pointer.
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0] shared_r, shared_nxt;
  logic [CUR_W-1:0]      cur_r, cur_nxt;

  // Latched input word and working registers.
  logic [rrq_pkg::THREAD_W-1:0] id_r;
  logic [rrq_pkg::PRIO_W-1:0]   pri_r;
  logic [rrq_pkg::PRIO_W-1:0]   hpri_r;
  logic [IDX_W-1:0]             scan_r;
  logic [IDX_W-1:0]             hit_r;
  logic [IDX_W-1:0]             bef_r;
  logic [IDX_W-1:0]             aft_r;
  logic                         bef_v_r;
  logic                         aft_v_r;
  logic [IDX_W-1:0]             x_r;
  logic [IDX_W-1:0]             m_r;
  logic [CUR_W-1:0]             run_r;
  rrq_pkg::slot_entry_t         xreg_r;

  // Result being built and the output register.
  logic [rrq_pkg::THREAD_W-1:0] res_thread_r;
  logic                         res_valid_r;
  logic [1:0]                   res_err_r;
  logic [rrq_pkg::THREAD_W-1:0] out_thread_r;
  logic                         out_valid_flag_r;
  logic [1:0]                   out_err_r;

  // Encoder outputs and compare results.
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic             used_any;
  logic [IDX_W-1:0] used_idx;
  logic             after_any;
  logic [IDX_W-1:0] after_idx;
  logic [IDX_W-1:0] pick_idx;
  logic [CUR_W-1:0] run_len;
  logic             hit;
  logic             hit_shared;
  logic             scan_last;
  logic             sh_match;
  logic             sh_lt;
  logic             sh_gt;
  logic             bef_v_fin;
  logic             aft_v_fin;
  logic [IDX_W-1:0] bef_fin;
  logic [IDX_W-1:0] aft_fin;
  logic             swap;
  logic             tie;

  // Lowest free slot and lowest used slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    used_any = 1'b0;
    used_idx = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(j);
      end
      if (used_r[j]) begin
        used_any = 1'b1;
        used_idx = IDX_W'(j);
      end
    end
  end

  // Lowest used slot above the current pointer; otherwise wrap to the lowest used slot.
  always_comb begin
    after_any = 1'b0;
    after_idx = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (used_r[j] && (CUR_W'(j) > cur_r)) begin
        after_any = 1'b1;
        after_idx = IDX_W'(j);
      end
    end
  end

  assign pick_idx = after_any ? after_idx : used_idx;

  // Length of the leading run of used slots.
  assign run_len = free_any ? CUR_W'(free_idx) : CUR_W'(SLOT_COUNT);

  // Scan compares against the word read from the slot memory.
  assign hit        = used_r[scan_r] && (rd_r.thread == id_r);
  assign hit_shared = shared_r[scan_r];
  assign scan_last  = (scan_r == IDX_W'(SLOT_COUNT - 1));
  assign sh_match   = used_r[scan_r] && shared_r[scan_r] && (rd_r.prio == hpri_r);
  assign sh_lt      = scan_r < hit_r;
  assign sh_gt      = scan_r > hit_r;
  assign bef_v_fin  = bef_v_r || (sh_match && sh_lt);
  assign bef_fin    = (sh_match && sh_lt) ? scan_r : bef_r;
  assign aft_v_fin  = aft_v_r || (sh_match && sh_gt);
  assign aft_fin    = (sh_match && sh_gt) ? scan_r : aft_r;

  // Sort compare between the held row entry and the entry read at m.
  assign swap = xreg_r.prio > rd_r.prio;
  assign tie  = xreg_r.prio == rd_r.prio;

  // Status toward the controller.
  always_comb begin
    status.free_any   = free_any;
    status.used_any   = used_any;
    status.run_short  = run_len < CUR_W'(2);
    status.hit        = hit;
    status.hit_shared = hit_shared;
    status.scan_last  = scan_last;
    status.m_last     = CUR_W'(m_r) == (run_r - CUR_W'(1));
    status.x_last     = (CUR_W'(x_r) + CUR_W'(2)) == run_r;
  end

  // Slot memory address and write data selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{thread: id_r, prio: pri_r};
    mem_raddr = scan_r;
    unique case (op)
      rrq_pkg::DP_ADD: begin
        mem_we = free_any;
      end
      rrq_pkg::DP_PICK: begin
        mem_raddr = pick_idx;
      end
      rrq_pkg::DP_SX_RD: begin
        mem_raddr = x_r;
      end
      rrq_pkg::DP_SM_RD: begin
        mem_raddr = m_r;
      end
      rrq_pkg::DP_SM_CMP: begin
        mem_we    = swap;
        mem_waddr = m_r;
        mem_wdata = xreg_r;
      end
      rrq_pkg::DP_SX_WB: begin
        mem_we    = 1'b1;
        mem_waddr = x_r;
        mem_wdata = xreg_r;
      end
      default: begin
      end
    endcase
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_r <= slot_mem_r[mem_raddr];
  end

  // Next values of the occupancy bits, shared bits and current pointer.
  always_comb begin
    used_nxt   = used_r;
    shared_nxt = shared_r;
    cur_nxt    = cur_r;
    unique case (op)
      rrq_pkg::DP_ADD: begin
        if (free_any) begin
          used_nxt[free_idx]   = 1'b1;
          shared_nxt[free_idx] = 1'b0;
        end
      end
      rrq_pkg::DP_PICK: begin
        if (used_any) begin
          cur_nxt = CUR_W'(pick_idx);
        end
      end
      rrq_pkg::DP_REM_CMP: begin
        if (hit && !hit_shared) begin
          used_nxt[scan_r]   = 1'b0;
          shared_nxt[scan_r] = 1'b0;
        end
      end
      rrq_pkg::DP_SH_CMP: begin
        // Earlier slots win over later ones when the removed thread was shared.
        if (scan_last) begin
          used_nxt[hit_r]   = 1'b0;
          shared_nxt[hit_r] = 1'b0;
          if (bef_v_fin) begin
            cur_nxt = CUR_W'(bef_fin);
          end else if (aft_v_fin) begin
            cur_nxt = CUR_W'(aft_fin);
          end
        end
      end
      rrq_pkg::DP_SM_CMP: begin
        if (swap) begin
          shared_nxt[x_r] = shared_r[m_r];
          shared_nxt[m_r] = shared_r[x_r];
        end else if (tie) begin
          shared_nxt[x_r] = 1'b1;
          shared_nxt[m_r] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      shared_r <= '0;
      cur_r    <= CUR_W'(SLOT_COUNT);
    end else begin
      used_r   <= used_nxt;
      shared_r <= shared_nxt;
      cur_r    <= cur_nxt;
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    unique case (op)
      rrq_pkg::DP_LATCH: begin
        id_r         <= in_thread_id;
        pri_r        <= in_priority_value;
        res_thread_r <= '0;
        res_valid_r  <= 1'b0;
        res_err_r    <= rrq_pkg::ERR_OK;
        scan_r       <= '0;
      end
      rrq_pkg::DP_ADD: begin
        res_err_r <= free_any ? rrq_pkg::ERR_OK : rrq_pkg::ERR_FULL;
      end
      rrq_pkg::DP_PICK: begin
        res_valid_r <= used_any;
      end
      rrq_pkg::DP_PICK_RD: begin
        res_thread_r <= rd_r.thread;
      end
      rrq_pkg::DP_REM_CMP: begin
        if (hit) begin
          hit_r   <= scan_r;
          hpri_r  <= rd_r.prio;
          scan_r  <= '0;
          bef_v_r <= 1'b0;
          aft_v_r <= 1'b0;
        end else if (scan_last) begin
          res_err_r <= rrq_pkg::ERR_NOT_FOUND;
        end else begin
          scan_r <= scan_r + IDX_W'(1);
        end
      end
      rrq_pkg::DP_SH_CMP: begin
        bef_v_r <= bef_v_fin;
        bef_r   <= bef_fin;
        aft_v_r <= aft_v_fin;
        aft_r   <= aft_fin;
        scan_r  <= scan_r + IDX_W'(1);
      end
      rrq_pkg::DP_SORT_INIT: begin
        run_r <= run_len;
        x_r   <= '0;
      end
      rrq_pkg::DP_SX_LD: begin
        xreg_r <= rd_r;
        m_r    <= x_r + IDX_W'(1);
      end
      rrq_pkg::DP_SM_CMP: begin
        if (swap) begin
          xreg_r <= rd_r;
        end
        m_r <= m_r + IDX_W'(1);
      end
      rrq_pkg::DP_SX_WB: begin
        x_r <= x_r + IDX_W'(1);
      end
      rrq_pkg::DP_LOAD_OUT: begin
        out_thread_r     <= res_thread_r;
        out_valid_flag_r <= res_valid_r;
        out_err_r        <= res_err_r;
      end
      default: begin
      end
    endcase
  end

  assign out_picked_thread = out_thread_r;
  assign out_picked_valid  = out_valid_flag_r;
  assign out_error_code    = out_err_r;

endmodule

// ===== rtl/core/rrq_ctrl.sv =====
// Controller of the run queue: command sequencing and the word handshakes.
`timescale 1ns / 1ps

module rrq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rrq_pkg::dp_status_t status,
  output rrq_pkg::dp_op_t     op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_PICK,
    ST_PICK_RD,
    ST_REM_RD,
    ST_REM_CMP,
    ST_SH_RD,
    ST_SH_CMP,
    ST_SORT_INIT,
    ST_SX_RD,
    ST_SX_LD,
    ST_SM_RD,
    ST_SM_CMP,
    ST_SX_WB,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath operation.
  always_comb begin
    state_nxt = state_r;
    op        = rrq_pkg::DP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op = rrq_pkg::DP_LATCH;
          unique case (rrq_pkg::cmd_t'(in_command))
            rrq_pkg::CMD_ADD:    state_nxt = ST_ADD;
            rrq_pkg::CMD_REMOVE: state_nxt = ST_REM_RD;
            rrq_pkg::CMD_SORT:   state_nxt = ST_SORT_INIT;
            rrq_pkg::CMD_PICK:   state_nxt = ST_PICK;
          endcase
        end
      end
      ST_ADD: begin
        op        = rrq_pkg::DP_ADD;
        state_nxt = ST_DONE;
      end
      ST_PICK: begin
        op        = rrq_pkg::DP_PICK;
        state_nxt = status.used_any ? ST_PICK_RD : ST_DONE;
      end
      ST_PICK_RD: begin
        op        = rrq_pkg::DP_PICK_RD;
        state_nxt = ST_DONE;
      end
      ST_REM_RD: begin
        op        = rrq_pkg::DP_REM_RD;
        state_nxt = ST_REM_CMP;
      end
      ST_REM_CMP: begin
        op = rrq_pkg::DP_REM_CMP;
        if (status.hit) begin
          state_nxt = status.hit_shared ? ST_SH_RD : ST_DONE;
        end else if (status.scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_REM_RD;
        end
      end
      ST_SH_RD: begin
        op        = rrq_pkg::DP_SH_RD;
        state_nxt = ST_SH_CMP;
      end
      ST_SH_CMP: begin
        op        = rrq_pkg::DP_SH_CMP;
        state_nxt = status.scan_last ? ST_DONE : ST_SH_RD;
      end
      ST_SORT_INIT: begin
        op        = rrq_pkg::DP_SORT_INIT;
        state_nxt = status.run_short ? ST_DONE : ST_SX_RD;
      end
      ST_SX_RD: begin
        op        = rrq_pkg::DP_SX_RD;
        state_nxt = ST_SX_LD;
      end
      ST_SX_LD: begin
        op        = rrq_pkg::DP_SX_LD;
        state_nxt = ST_SM_RD;
      end
      ST_SM_RD: begin
        op        = rrq_pkg::DP_SM_RD;
        state_nxt = ST_SM_CMP;
      end
      ST_SM_CMP: begin
        op        = rrq_pkg::DP_SM_CMP;
        state_nxt = status.m_last ? ST_SX_WB : ST_SM_RD;
      end
      ST_SX_WB: begin
        op        = rrq_pkg::DP_SX_WB;
        state_nxt = status.x_last ? ST_DONE : ST_SX_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          op        = rrq_pkg::DP_LOAD_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, cleared when the word is taken.
  always_comb begin
    if (op == rrq_pkg::DP_LOAD_OUT) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/round_robin_run_queue_unit.sv =====
// Top level of the round-robin run queue: controller and datapath.
`timescale 1ns / 1ps

// Round-robin run queue over SLOT_COUNT thread slots. Each input word carries a
// command (add, remove, sort, pick) and returns exactly one result word. One
// command is worked on at a time; the next input word is taken while the last
// result still waits in the output register. Slot contents sit in a memory with
// one write port and a registered read port, so each scanned slot passes a read
// state and a compare state. Remove scans slots up to and including the matching
// one (every slot when no slot matches), and scans every slot once more when the
// removed thread carries the shared mark. Sort compares every slot pair of a
// leading run of n >= 2 used slots (one memory read and one compare per slot
// pair) and skips the compare pass when the run is shorter.
// No clearing pass is needed after reset.
module round_robin_run_queue_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [rrq_pkg::THREAD_W-1:0] in_thread_id,
  input  logic [rrq_pkg::PRIO_W-1:0]   in_priority_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rrq_pkg::THREAD_W-1:0] out_picked_thread,
  output logic                         out_picked_valid,
  output logic [1:0]                   out_error_code
);

  rrq_pkg::dp_op_t     op;
  rrq_pkg::dp_status_t status;

  // Command sequencing and handshakes.
  rrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .op         (op)
  );

  // Slot storage and scans.
  rrq_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .in_thread_id      (in_thread_id),
    .in_priority_value (in_priority_value),
    .status            (status),
    .out_picked_thread (out_picked_thread),
    .out_picked_valid  (out_picked_valid),
    .out_error_code    (out_error_code)
  );

endmodule
